FILE: hw/rtl/quadratic_root_solver_defines.svh
// assertion macros for the solver rtl
`ifndef QUADRATIC_ROOT_SOLVER_DEFINES_SVH
`define QUADRATIC_ROOT_SOLVER_DEFINES_SVH

// implication checked on every edge outside reset
`define QRS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("qrs check failed");

// implication whose consequent is checked in the next cycle
`define QRS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("qrs check failed");

`endif

FILE: hw/rtl/qrs_pkg.sv
package qrs_pkg;

  typedef struct packed {
    logic signed [15:0] coef_a;
    logic signed [15:0] coef_b;
    logic signed [15:0] coef_c;
    logic               restart;
  } qrs_in_t;

  typedef struct packed {
    logic [1:0]         root_count;
    logic signed [31:0] root_low;
    logic signed [31:0] root_high;
    logic signed [31:0] vertex_x;
    logic               not_quadratic;
    logic               saturated;
    logic               tracked_valid;
    logic signed [31:0] tracked_min;
    logic signed [31:0] tracked_max;
  } qrs_out_t;

  // datapath operation codes
  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL,
    OP_SQRT_STEP,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_DIV_STORE,
    OP_FINISH
  } qrs_op_t;

  // which quotient the divider is producing
  typedef enum logic [1:0] {
    DSEL_VX,
    DSEL_R1,
    DSEL_R2
  } qrs_dsel_t;

  typedef struct packed {
    qrs_op_t   op;
    qrs_dsel_t dsel;
  } qrs_cmd_t;

  typedef struct packed {
    logic nq;
    logic d_zero;
    logic d_pos;
  } qrs_sts_t;

  localparam int SqrtSteps = 33;
  localparam int DivSteps  = 50;
  localparam int StepW     = 6;

endpackage

FILE: hw/rtl/quadratic_root_solver.sv
// channel  | ports                      | word
// input    | in_valid in_stall in_data  | coef_a coef_b coef_c restart
// result   | out_valid out_stall out_data | roots, vertex, flags, tracker
//
// one word at a time: load, multiply, 33 sqrt steps, then a
// 50-step restoring divide for the vertex, plus one for each of two roots when d > 0
// when a is zero the sqrt and divides are skipped
// the sqrt and the divides run one after another on one datapath
// synchronous active low reset clears the tracker, the result word and control
// a result holds under out_stall; no new word is taken until it leaves
module quadratic_root_solver
  import qrs_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  qrs_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output qrs_out_t out_data
);

  qrs_cmd_t cmd;
  qrs_sts_t sts;

  // sequencer
  qrs_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall,
    .sts, .cmd
  );

  // arithmetic and tracker
  qrs_datapath u_dp (
    .clk, .rst_n, .in_word(in_data), .cmd, .sts, .res(out_data)
  );

endmodule

FILE: hw/rtl/qrs_datapath.sv
module qrs_datapath
  import qrs_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  qrs_in_t  in_word,
  input  qrs_cmd_t cmd,
  output qrs_sts_t sts,
  output qrs_out_t res
);

  logic signed [15:0] a_r, b_r, c_r;
  logic               restart_r;
  logic signed [35:0] d_r;
  logic [33:0]        rad_r;
  logic [35:0]        rem_r;
  logic [32:0]        root_r;
  logic [5:0]         sqk_r;
  // divider: magnitude numerator, divisor, partial remainder
  logic [49:0]        num_r;
  logic [17:0]        dvs_r;
  logic [18:0]        drem_r;
  logic               neg_r;
  logic signed [31:0] vx_r, r1_r, r2_r;
  logic               sat_r;
  logic               tv_r;
  logic signed [31:0] tmin_r, tmax_r;

  logic signed [32:0] bb;
  logic signed [34:0] ac4;
  logic [35:0]        sq_rem, sq_trial;
  logic [1:0]         sq_pair;
  logic signed [49:0] nb, numer;
  logic [18:0]        dr_sh;
  logic signed [50:0] q_s;
  logic signed [31:0] q_c;
  logic               q_sat;
  logic signed [31:0] lo, hi;
  logic signed [16:0] den;

  assign bb  = 33'(32'(b_r) * 32'(b_r));
  assign ac4 = 35'(32'(a_r) * 32'(c_r)) <<< 2;
  assign den = 17'(a_r) <<< 1;
  assign nb  = -(50'(b_r) <<< 16);

  assign sq_pair  = (sqk_r < 6'd17) ? rad_r[33:32] : 2'd0;
  assign sq_rem   = {rem_r[33:0], sq_pair};
  assign sq_trial = {1'b0, root_r[32:0], 2'b01};

  always_comb begin
    unique case (cmd.dsel)
      DSEL_R1: numer = nb + 50'($signed({1'b0, root_r}));
      DSEL_R2: numer = nb - 50'($signed({1'b0, root_r}));
      default: numer = nb;
    endcase
  end

  assign dr_sh = {drem_r[17:0], num_r[49]};

  // signed quotient and clip
  assign q_s = neg_r ? -$signed({1'b0, num_r}) : $signed({1'b0, num_r});
  always_comb begin
    q_sat = 1'b0;
    q_c   = q_s[31:0];
    if (q_s > 51'sd2147483647) begin
      q_c = 32'sh7fffffff; q_sat = 1'b1;
    end else if (q_s < -51'sd2147483648) begin
      q_c = 32'sh80000000; q_sat = 1'b1;
    end
  end

  assign lo = (r1_r < r2_r) ? r1_r : r2_r;
  assign hi = (r1_r < r2_r) ? r2_r : r1_r;

  assign sts.nq     = (a_r == 16'sd0);
  assign sts.d_zero = (d_r == 36'sd0);
  assign sts.d_pos  = (d_r > 36'sd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tv_r   <= 1'b0;
      tmin_r <= '0;
      tmax_r <= '0;
      res    <= '0;
    end else begin
      case (cmd.op)
        OP_LOAD: begin
          a_r <= in_word.coef_a; b_r <= in_word.coef_b; c_r <= in_word.coef_c;
          restart_r <= in_word.restart;
          sat_r <= 1'b0;
          r1_r <= '0; r2_r <= '0; vx_r <= '0;
        end
        OP_MUL: begin
          d_r    <= 36'(bb) - 36'(ac4);
          rad_r  <= 34'(36'(bb) - 36'(ac4));
          rem_r  <= '0;
          root_r <= '0;
          sqk_r  <= '0;
        end
        OP_SQRT_STEP: begin
          rad_r <= rad_r << 2;
          sqk_r <= sqk_r + 6'd1;
          if (sq_rem >= sq_trial) begin
            rem_r  <= sq_rem - sq_trial;
            root_r <= {root_r[31:0], 1'b1};
          end else begin
            rem_r  <= sq_rem;
            root_r <= {root_r[31:0], 1'b0};
          end
        end
        OP_DIV_INIT: begin
          num_r  <= numer[49] ? 50'(-numer) : numer;
          dvs_r  <= den[16] ? -18'(den) : 18'(den);
          neg_r  <= numer[49] ^ den[16];
          drem_r <= '0;
        end
        OP_DIV_STEP: begin
          if (dr_sh >= {1'b0, dvs_r}) begin
            drem_r <= dr_sh - {1'b0, dvs_r};
            num_r  <= {num_r[48:0], 1'b1};
          end else begin
            drem_r <= dr_sh;
            num_r  <= {num_r[48:0], 1'b0};
          end
        end
        OP_DIV_STORE: begin
          sat_r <= sat_r | q_sat;
          unique case (cmd.dsel)
            DSEL_R1: r1_r <= q_c;
            DSEL_R2: r2_r <= q_c;
            default: begin
              vx_r <= q_c;
              r1_r <= q_c;
              r2_r <= q_c;
            end
          endcase
        end
        OP_FINISH: begin
          logic               has;
          logic               tv0;
          logic signed [31:0] mn0, mx0;
          has = !sts.nq && (sts.d_zero || sts.d_pos);
          tv0 = restart_r ? 1'b0 : tv_r;
          mn0 = restart_r ? 32'sd0 : tmin_r;
          mx0 = restart_r ? 32'sd0 : tmax_r;
          if (has) begin
            if (!tv0) begin
              mn0 = lo; mx0 = hi; tv0 = 1'b1;
            end else begin
              if (lo < mn0) mn0 = lo;
              if (hi > mx0) mx0 = hi;
            end
          end
          tv_r <= tv0; tmin_r <= mn0; tmax_r <= mx0;
          res.root_count    <= sts.nq ? 2'd0 : (sts.d_zero ? 2'd1 : (sts.d_pos ? 2'd2 : 2'd0));
          res.root_low      <= has ? lo : 32'sd0;
          res.root_high     <= has ? hi : 32'sd0;
          res.vertex_x      <= sts.nq ? 32'sd0 : vx_r;
          res.not_quadratic <= sts.nq;
          res.saturated     <= sts.nq ? 1'b0 : sat_r;
          res.tracked_valid <= tv0;
          res.tracked_min   <= mn0;
          res.tracked_max   <= mx0;
        end
        default: ;
      endcase
    end
  end

endmodule

FILE: hw/rtl/qrs_ctrl.sv
module qrs_ctrl
  import qrs_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  qrs_sts_t sts,
  output qrs_cmd_t cmd
);
  `include "quadratic_root_solver_defines.svh"

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_SQRT, S_VINIT, S_VDIV, S_VSTORE,
    S_DINIT, S_DDIV, S_DSTORE, S_FIN, S_OUT
  } state_t;

  state_t     state_r, state_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  qrs_dsel_t  dsel_r, dsel_nxt;
  logic       ov_r, ov_nxt;

  assign in_stall  = (state_r != S_IDLE) || ov_r;
  assign out_valid = ov_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    dsel_nxt  = dsel_r;
    ov_nxt    = ov_r && out_stall;
    cmd.op    = OP_NONE;
    cmd.dsel  = dsel_r;
    unique case (state_r)
      S_IDLE: if (in_valid && !in_stall) begin
        cmd.op = OP_LOAD; state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.op = OP_MUL; cnt_nxt = '0;
        state_nxt = sts.nq ? S_FIN : S_SQRT;
      end
      S_SQRT: begin
        cmd.op = OP_SQRT_STEP; cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'(SqrtSteps - 1)) state_nxt = S_VINIT;
      end
      S_VINIT: begin
        cmd.op = OP_DIV_INIT; cmd.dsel = DSEL_VX; dsel_nxt = DSEL_VX;
        cnt_nxt = '0; state_nxt = S_VDIV;
      end
      S_VDIV, S_DDIV: begin
        cmd.op = OP_DIV_STEP; cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'(DivSteps - 1))
          state_nxt = (state_r == S_VDIV) ? S_VSTORE : S_DSTORE;
      end
      S_VSTORE: begin
        cmd.op = OP_DIV_STORE;
        if (sts.d_pos) begin
          dsel_nxt = DSEL_R1; state_nxt = S_DINIT;
        end else state_nxt = S_FIN;
      end
      S_DINIT: begin
        cmd.op = OP_DIV_INIT; cnt_nxt = '0; state_nxt = S_DDIV;
      end
      S_DSTORE: begin
        cmd.op = OP_DIV_STORE;
        if (dsel_r == DSEL_R1) begin
          dsel_nxt = DSEL_R2; state_nxt = S_DINIT;
        end else state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.op = OP_FINISH; ov_nxt = 1'b1; state_nxt = S_OUT;
      end
      S_OUT: if (!ov_r || !out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      dsel_r  <= DSEL_VX;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      dsel_r  <= dsel_nxt;
      ov_r    <= ov_nxt;
    end
  end

  `QRS_ASSERT_IMP(a_no_take_busy, state_r != S_IDLE, in_stall)
  `QRS_ASSERT_NEXT(a_fin_valid, state_r == S_FIN, out_valid)
  `QRS_ASSERT_NEXT(a_hold_valid, out_valid && out_stall, out_valid)

endmodule
